// ===== design/srtl_pkg.sv =====
// Shared types, codes and defaults for the sorted range table lookup core.
// Used by srtl_front, srtl_back and the top level; depends on nothing.
package srtl_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int MAX_RUN_DEF     = 64;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_READ   = 2'd2,
		ACT_CLEAR  = 2'd3
	} act_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_NOT_FOUND = 4'd1,
		ST_BAD_ENTRY = 4'd2,
		ST_ORDER     = 4'd3,
		ST_FULL      = 4'd4,
		ST_HIT       = 4'd5,
		ST_DUP       = 4'd6,
		ST_BAD_INDEX = 4'd7,
		ST_RUN_CUT   = 4'd8
	} status_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		act_t        act;
		logic        bad;
		logic [62:0] key;
		logic [31:0] from_pos;
		logic [31:0] to_pos;
		logic [9:0]  idx;
	} cmd_t;

	// One result item.
	typedef struct packed {
		status_t     status;
		logic [62:0] key;
		logic [31:0] from_pos;
		logic [31:0] to_pos;
		logic        hit;
		logic [9:0]  pos;
		logic [10:0] cnt;
		logic [10:0] hits;
		logic        all;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EXEC,
		B_SRCH,
		B_SCMP,
		B_RCHK,
		B_FLUSH,
		B_RDOUT
	} bst_t;

endpackage

// ===== design/srtl_front.sv =====
// Front part: accepts items, flags malformed loads and queues them.
// Depends on srtl_pkg.
module srtl_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic [1:0]     action,
	input  logic [62:0]    key,
	input  logic [31:0]    from_pos,
	input  logic [31:0]    to_pos,
	input  logic [9:0]     entry_index,
	output logic           q_valid,
	output srtl_pkg::cmd_t q_head,
	input  logic           q_pop
);
	import srtl_pkg::*;

	cmd_t       q_mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       pop;
	cmd_t       cmd_in;

	assign busy    = (cnt_q == 2'(QUEUE_DEPTH));
	assign accept  = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign pop     = q_pop && q_valid;
	assign q_head  = q_mem_q[rd_ptr_q];

	always_comb begin
		cmd_in.act      = act_t'(action);
		cmd_in.bad      = (key == 63'd0) || (from_pos == 32'd0) || (to_pos == 32'd0)
			|| (from_pos > to_pos);
		cmd_in.key      = key;
		cmd_in.from_pos = from_pos;
		cmd_in.to_pos   = to_pos;
		cmd_in.idx      = entry_index;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(accept) - 2'(pop);
		end
	end

endmodule

// ===== design/srtl_back.sv =====
// Back part: table memories, binary search, run emission and result register.
// Depends on srtl_pkg.
module srtl_back #(
	parameter int TABLE_DEPTH = srtl_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_RUN     = srtl_pkg::MAX_RUN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  srtl_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           res_valid,
	output srtl_pkg::res_t res
);
	import srtl_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = $clog2(MAX_RUN + 1);
	localparam int XW = (CW > 10) ? CW : 10;

	logic [62:0] key_mem  [TABLE_DEPTH];
	logic [31:0] from_mem [TABLE_DEPTH];
	logic [31:0] to_mem   [TABLE_DEPTH];
	logic        hit_mem  [TABLE_DEPTH];

	bst_t        state_q, state_d;
	cmd_t        cmd_q;
	logic [CW-1:0] held_q, held_d, hits_q, hits_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, i_q, i_d;
	logic [NW-1:0] n_q, n_d;
	res_t        pend_q, pend_d;
	logic [126:0] tail_q;
	logic        tail_we;
	logic        res_valid_q, emit;
	res_t        res_q, emit_res;

	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en, hit_we, hit_wdata;
	logic [AW-1:0] hit_addr;
	logic [62:0]   rd_key;
	logic [31:0]   rd_from, rd_to;
	logic          rd_hit;

	logic [CW-1:0] mid_c, inext;
	logic          idx_ok;

	function automatic res_t mk_res(status_t st, logic [62:0] k, logic [31:0] f,
			logic [31:0] t, logic h, logic [9:0] p, logic [CW-1:0] hc,
			logic [CW-1:0] ht, logic l);
		res_t r;
		r.status   = st;
		r.key      = k;
		r.from_pos = f;
		r.to_pos   = t;
		r.hit      = h;
		r.pos      = p;
		r.cnt      = 11'(hc);
		r.hits     = 11'(ht);
		r.all      = (hc != '0) && (hc == ht);
		r.last     = l;
		return r;
	endfunction

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);
	assign inext     = i_q + CW'(1);
	assign idx_ok    = XW'(cmd_q.idx) < XW'(held_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]  <= cmd_q.key;
			from_mem[wr_addr] <= cmd_q.from_pos;
			to_mem[wr_addr]   <= cmd_q.to_pos;
		end
		rd_key  <= key_mem[rd_addr];
		rd_from <= from_mem[rd_addr];
		rd_to   <= to_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (hit_we) hit_mem[hit_addr] <= hit_wdata;
		rd_hit <= hit_mem[rd_addr];
	end

	always_comb begin
		state_d   = state_q;
		held_d    = held_q;
		hits_d    = hits_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		i_d       = i_q;
		n_d       = n_q;
		pend_d    = pend_q;
		tail_we   = 1'b0;
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_res  = pend_q;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = held_q[AW-1:0];
		hit_we    = 1'b0;
		hit_addr  = held_q[AW-1:0];
		hit_wdata = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				q_pop = q_valid;
				if (q_valid) state_d = B_EXEC;
			end
			B_EXEC: begin
				state_d = B_IDLE;
				unique case (cmd_q.act)
					ACT_LOAD: begin
						emit = 1'b1;
						emit_res = mk_res(ST_OK, cmd_q.key, cmd_q.from_pos, cmd_q.to_pos,
							1'b0, 10'd0, held_q, hits_q, 1'b1);
						if (cmd_q.bad) begin
							emit_res.status = ST_BAD_ENTRY;
						end else if (held_q != '0 &&
								{cmd_q.key, cmd_q.from_pos, cmd_q.to_pos} == tail_q) begin
							emit_res.status = ST_DUP;
						end else if (held_q != '0 &&
								{cmd_q.key, cmd_q.from_pos, cmd_q.to_pos} < tail_q) begin
							emit_res.status = ST_ORDER;
						end else if (held_q >= CW'(TABLE_DEPTH)) begin
							emit_res.status = ST_FULL;
						end else begin
							wr_en     = 1'b1;
							hit_we    = 1'b1;
							tail_we   = 1'b1;
							held_d    = held_q + CW'(1);
							emit_res  = mk_res(ST_OK, cmd_q.key, cmd_q.from_pos,
								cmd_q.to_pos, 1'b0, 10'(held_q), held_d, hits_q, 1'b1);
						end
					end
					ACT_LOOKUP: begin
						lo_d    = '0;
						hi_d    = held_q;
						state_d = B_SRCH;
					end
					ACT_READ: begin
						if (idx_ok) begin
							rd_addr = AW'(cmd_q.idx);
							state_d = B_RDOUT;
						end else begin
							emit = 1'b1;
							emit_res = mk_res(ST_BAD_INDEX, 63'd0, 32'd0, 32'd0, 1'b0,
								cmd_q.idx, held_q, hits_q, 1'b1);
						end
					end
					ACT_CLEAR: begin
						held_d = '0;
						hits_d = '0;
						emit = 1'b1;
						emit_res = mk_res(ST_OK, 63'd0, 32'd0, 32'd0, 1'b0, 10'd0,
							'0, '0, 1'b1);
					end
					default: state_d = B_IDLE;
				endcase
			end
			B_SRCH: begin
				if (lo_q < hi_q) begin
					rd_addr = mid_c[AW-1:0];
					mid_d   = mid_c;
					state_d = B_SCMP;
				end else if (lo_q < held_q) begin
					rd_addr = lo_q[AW-1:0];
					i_d     = lo_q;
					n_d     = '0;
					state_d = B_RCHK;
				end else begin
					emit = 1'b1;
					emit_res = mk_res(ST_NOT_FOUND, cmd_q.key, 32'd0, 32'd0, 1'b0, 10'd0,
						held_q, hits_q, 1'b1);
					state_d = B_IDLE;
				end
			end
			B_SCMP: begin
				if (rd_key < cmd_q.key) lo_d = mid_q + CW'(1);
				else hi_d = mid_q;
				state_d = B_SRCH;
			end
			B_RCHK: begin
				if (rd_key != cmd_q.key) begin
					// End of the run, or no entry with this key at all.
					emit = 1'b1;
					if (n_q == '0) begin
						emit_res = mk_res(ST_NOT_FOUND, cmd_q.key, 32'd0, 32'd0, 1'b0,
							10'd0, held_q, hits_q, 1'b1);
					end else begin
						emit_res.last = 1'b1;
					end
					state_d = B_IDLE;
				end else if (n_q == NW'(MAX_RUN)) begin
					// The run goes on past the limit: cut it at the held result.
					emit = 1'b1;
					emit_res.last   = 1'b1;
					emit_res.status = ST_RUN_CUT;
					state_d = B_IDLE;
				end else begin
					emit = (n_q != '0);
					if (rd_hit) begin
						pend_d = mk_res(ST_HIT, cmd_q.key, rd_from, rd_to, 1'b1,
							10'(i_q), held_q, hits_q, 1'b0);
						state_d = B_FLUSH;
					end else begin
						hit_we    = 1'b1;
						hit_addr  = i_q[AW-1:0];
						hit_wdata = 1'b1;
						hits_d    = hits_q + CW'(1);
						pend_d = mk_res(ST_OK, cmd_q.key, rd_from, rd_to, 1'b1,
							10'(i_q), held_q, hits_d, 1'b0);
						n_d = n_q + NW'(1);
						i_d = inext;
						if (inext < held_q) begin
							rd_addr = inext[AW-1:0];
						end else begin
							state_d = B_FLUSH;
						end
					end
				end
			end
			B_FLUSH: begin
				emit = 1'b1;
				emit_res.last = 1'b1;
				state_d = B_IDLE;
			end
			B_RDOUT: begin
				emit = 1'b1;
				emit_res = mk_res(ST_OK, rd_key, rd_from, rd_to, rd_hit, cmd_q.idx,
					held_q, hits_q, 1'b1);
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_head;
		if (tail_we) tail_q <= {cmd_q.key, cmd_q.from_pos, cmd_q.to_pos};
		if (emit) res_q <= emit_res;
		pend_q <= pend_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		mid_q  <= mid_d;
		i_q    <= i_d;
		n_q    <= n_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			held_q      <= '0;
			hits_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			held_q      <= held_d;
			hits_q      <= hits_d;
			res_valid_q <= emit;
		end
	end

endmodule

// ===== design/sorted_range_table_leftmost_lookup_core.sv =====
// Top level of the sorted range table lookup core.
// Instantiates srtl_front and srtl_back; depends on srtl_pkg.
//
// An item is taken when start is high and busy is low; busy rises only while the
// two-entry queue between the front and the back is full. Results appear for one
// cycle under res_valid and cannot be held off, so the receiver must take every
// result in the cycle it is shown; last marks the final result of an item. With the
// back part idle, a load or clear passes through the queue, the command register and
// the result register, and a read also through the registered table read. A lookup
// runs binary-search steps, each a memory read and then a compare, then gives one
// result per matching entry of the run, one entry per cycle, the final one marked
// last.
// No clearing pass is needed after reset: hit marks are rewritten when each entry is
// loaded and every table read is bounded by the entry count.
module sorted_range_table_leftmost_lookup_core #(
	parameter int TABLE_DEPTH = srtl_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_RUN     = srtl_pkg::MAX_RUN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [62:0] key,
	input  logic [31:0] from_pos,
	input  logic [31:0] to_pos,
	input  logic [9:0]  entry_index,
	output logic        res_valid,
	output logic [3:0]  status,
	output logic [62:0] key_res,
	output logic [31:0] from_pos_res,
	output logic [31:0] to_pos_res,
	output logic        hit_flag,
	output logic [9:0]  position,
	output logic [10:0] entry_count,
	output logic [10:0] hits_total,
	output logic        all_found,
	output logic        last
);
	import srtl_pkg::*;

	logic q_valid, q_pop;
	cmd_t q_head;
	res_t res;

	// The front decodes the item and checks a load's fields for validity.
	srtl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.key         (key),
		.from_pos    (from_pos),
		.to_pos      (to_pos),
		.entry_index (entry_index),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop)
	);

	// The back owns the table and the counts and produces every result.
	srtl_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_RUN     (MAX_RUN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res       (res)
	);

	assign status       = res.status;
	assign key_res      = res.key;
	assign from_pos_res = res.from_pos;
	assign to_pos_res   = res.to_pos;
	assign hit_flag     = res.hit;
	assign position     = res.pos;
	assign entry_count  = res.cnt;
	assign hits_total   = res.hits;
	assign all_found    = res.all;
	assign last         = res.last;

	// More entries can never be hit than are held.
	a_hits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> hits_total <= entry_count)
		else $error("hit total exceeds entry count");

	// The completion flag agrees with the two counts it summarizes.
	a_all_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> all_found == (entry_count != 11'd0 && entry_count == hits_total))
		else $error("all_found inconsistent with counts");

	// A miss or a run cut always closes its item.
	a_final_codes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_NOT_FOUND || status == ST_RUN_CUT) |-> last)
		else $error("miss or cut result not marked last");

	// A miss reports no start of range and is not flagged as a hit.
	a_miss_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_NOT_FOUND |-> from_pos_res == 32'd0 && !hit_flag)
		else $error("miss result carries range data");

endmodule
